// File: src/walu_pkg.sv
`default_nettype none

package walu_pkg;

  localparam int DATA_W    = 64;
  localparam int SHIFT_W   = $clog2(DATA_W);
  localparam int CMD_W     = 5;
  localparam int WIDTH_W   = 7;
  localparam int CC_W      = 4;
  localparam int FLAGS_W   = 4;
  localparam int S_FIELD_W = CMD_W + 3 * DATA_W + 2 * WIDTH_W + CC_W + FLAGS_W;
  localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int M_FIELD_W = DATA_W + 1;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [WIDTH_W-1:0] width_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PASS   = 5'd0,
    CMD_ADD    = 5'd1,
    CMD_SUB    = 5'd2,
    CMD_AND    = 5'd3,
    CMD_OR     = 5'd4,
    CMD_XOR    = 5'd5,
    CMD_SHL    = 5'd6,
    CMD_LSR    = 5'd7,
    CMD_ASR    = 5'd8,
    CMD_TRUNC  = 5'd9,
    CMD_ZEXT   = 5'd10,
    CMD_SEXT   = 5'd11,
    CMD_EQ     = 5'd12,
    CMD_NE     = 5'd13,
    CMD_ULT    = 5'd14,
    CMD_SLT    = 5'd15,
    CMD_SELECT = 5'd16,
    CMD_ADDC   = 5'd17,
    CMD_SUBC   = 5'd18,
    CMD_ADDV   = 5'd19,
    CMD_SUBV   = 5'd20,
    CMD_COND   = 5'd21
  } cmd_t;

  typedef enum logic [CC_W-1:0] {
    CC_EQ = 4'd0, CC_NE = 4'd1, CC_CS = 4'd2, CC_CC = 4'd3,
    CC_MI = 4'd4, CC_PL = 4'd5, CC_VS = 4'd6, CC_VC = 4'd7,
    CC_HI = 4'd8, CC_LS = 4'd9, CC_GE = 4'd10, CC_LT = 4'd11,
    CC_GT = 4'd12, CC_LE = 4'd13, CC_AL = 4'd14, CC_NV = 4'd15
  } cond_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    data_t              operand_a;
    data_t              operand_b;
    data_t              operand_c;
    width_t             result_width;
    width_t             source_width;
    logic [CC_W-1:0]    condition_code;
    logic [FLAGS_W-1:0] flags_nzcv;
  } alu_item_t;

  typedef struct packed {
    data_t result_value;
    logic  status;
  } alu_result_t;

endpackage

`default_nettype wire

// File: src/width_generic_ir_alu_top.sv
`default_nettype none

// Integer ALU that works at a per-operation bit width. Each transfer on the
// s_ side carries one operation (command, three 64-bit operands, result and
// source widths, a condition code and NZCV flags) and yields exactly one
// transfer on the m_ side with the result masked to the result width and a
// status bit that flags a shift amount at or above the result width. Widths
// of 0 act as 1 and widths above 64 act as 64; unused commands return 0.
// The path has two registers: the input transfer loads the input register,
// and the result register then loads from it through the single-pass ALU
// logic and raises m_tvalid, after which the result can transfer. Throughput
// is one operation per cycle while m_tready keeps up; both registers advance
// together whenever the result register is empty or draining. While a result
// waits on m_tready a new item is still taken if the input register is
// empty; with both registers full s_tready stays low until m_tready returns.
// The block keeps no state between operations and needs no setup after rst.
module width_generic_ir_alu_top import walu_pkg::*; (
  input  var logic                 clk,
  input  var logic                 rst,
  input  var logic                 s_tvalid,
  output var logic                 s_tready,
  // command, operand_a, operand_b, operand_c, result_width, source_width,
  // condition_code, flags_nzcv from bit 0 up, zero padded to 224 bits
  input  var logic [S_TDATA_W-1:0] s_tdata,
  output var logic                 m_tvalid,
  input  var logic                 m_tready,
  // result_value, status from bit 0 up, zero padded to 72 bits
  output var logic [M_TDATA_W-1:0] m_tdata
);

  alu_item_t   in_item;
  alu_item_t   item;        // input register
  logic        item_valid;
  alu_result_t alu_out;
  alu_result_t res;         // result register
  logic        res_free;
  logic        item_move;

  // unpack the input transfer, lowest field first
  assign in_item.command        = s_tdata[CMD_W-1:0];
  assign in_item.operand_a      = s_tdata[CMD_W +: DATA_W];
  assign in_item.operand_b      = s_tdata[CMD_W + DATA_W +: DATA_W];
  assign in_item.operand_c      = s_tdata[CMD_W + 2*DATA_W +: DATA_W];
  assign in_item.result_width   = s_tdata[CMD_W + 3*DATA_W +: WIDTH_W];
  assign in_item.source_width   = s_tdata[CMD_W + 3*DATA_W + WIDTH_W +: WIDTH_W];
  assign in_item.condition_code = s_tdata[CMD_W + 3*DATA_W + 2*WIDTH_W +: CC_W];
  assign in_item.flags_nzcv     = s_tdata[CMD_W + 3*DATA_W + 2*WIDTH_W + CC_W +: FLAGS_W];

  // result register can load when empty or being drained this cycle
  assign res_free  = !m_tvalid || m_tready;
  assign item_move = item_valid && res_free;
  assign s_tready  = !item_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= in_item;
    end
  end

  walu_alu u_alu (
    .item   (item),
    .result (alu_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      res <= alu_out;
    end
  end

  assign m_tdata = {{(M_TDATA_W - M_FIELD_W){1'b0}}, res.status, res.result_value};

  // a shift out of range always reports a zero value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status |-> res.result_value == '0)
    else $error("shift error with nonzero result");

  // an item held in the input register reaches the output once there is room
  assert property (@(posedge clk) disable iff (rst)
    item_move |=> m_tvalid)
    else $error("item lost between input and result register");

  // a stalled input register keeps its item
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !res_free |=> item_valid && $stable(item))
    else $error("input register changed while stalled");

  // an empty input register always takes a transfer
  assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_tready)
    else $error("ready low with empty input register");

endmodule

`default_nettype wire

// File: src/walu_alu.sv
`default_nettype none

module walu_alu import walu_pkg::*; (
  input  var alu_item_t   item,
  output var alu_result_t result
);

  // 0 reads as 1, anything above the data width as the data width
  function automatic width_t clamp_width(input width_t w);
    width_t r;
    r = w;
    if (w == '0) begin
      r = WIDTH_W'(1);
    end else if (w > WIDTH_W'(DATA_W)) begin
      r = WIDTH_W'(DATA_W);
    end
    return r;
  endfunction

  function automatic data_t width_mask(input width_t w);
    data_t m;
    if (w >= WIDTH_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = ~({DATA_W{1'b1}} << w);
    end
    return m;
  endfunction

  function automatic logic top_bit(input data_t v, input width_t w);
    logic [SHIFT_W-1:0] idx;
    idx = SHIFT_W'(w - WIDTH_W'(1));
    return v[idx];
  endfunction

  width_t rw, sw;
  data_t  rmask, smask, sa, sb, rv, rv_ext, sum_s, diff_s, sa_ext, sb_ext;
  logic [SHIFT_W-1:0] sh;
  logic   shift_err, n_f, z_f, c_f, v_f, cond_ok;
  data_t  r;
  logic   st;

  assign rw     = clamp_width(item.result_width);
  assign sw     = clamp_width(item.source_width);
  assign rmask  = width_mask(rw);
  assign smask  = width_mask(sw);
  assign sa     = item.operand_a & smask;
  assign sb     = item.operand_b & smask;
  assign rv     = item.operand_a & rmask;
  // value sign-extended from the result width, feeds the arithmetic shift
  assign rv_ext = top_bit(rv, rw) ? (rv | ~rmask) : rv;
  assign sa_ext = top_bit(sa, sw) ? (sa | ~smask) : sa;
  assign sb_ext = top_bit(sb, sw) ? (sb | ~smask) : sb;
  assign sum_s  = (sa + sb) & smask;
  assign diff_s = (sa - sb) & smask;
  assign sh     = item.operand_b[SHIFT_W-1:0];
  assign shift_err = item.operand_b >= DATA_W'(rw);
  assign {n_f, z_f, c_f, v_f} = item.flags_nzcv;

  always_comb begin
    unique case (cond_t'(item.condition_code))
      CC_EQ:   cond_ok = z_f;
      CC_NE:   cond_ok = !z_f;
      CC_CS:   cond_ok = c_f;
      CC_CC:   cond_ok = !c_f;
      CC_MI:   cond_ok = n_f;
      CC_PL:   cond_ok = !n_f;
      CC_VS:   cond_ok = v_f;
      CC_VC:   cond_ok = !v_f;
      CC_HI:   cond_ok = c_f && !z_f;
      CC_LS:   cond_ok = !c_f || z_f;
      CC_GE:   cond_ok = n_f == v_f;
      CC_LT:   cond_ok = n_f != v_f;
      CC_GT:   cond_ok = !z_f && (n_f == v_f);
      CC_LE:   cond_ok = z_f || (n_f != v_f);
      CC_AL:   cond_ok = 1'b1;
      CC_NV:   cond_ok = 1'b0;
      default: cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    r  = '0;
    st = 1'b0;
    unique case (item.command)
      CMD_PASS:   r = item.operand_a;
      CMD_ADD:    r = item.operand_a + item.operand_b;
      CMD_SUB:    r = item.operand_a - item.operand_b;
      CMD_AND:    r = item.operand_a & item.operand_b;
      CMD_OR:     r = item.operand_a | item.operand_b;
      CMD_XOR:    r = item.operand_a ^ item.operand_b;
      CMD_SHL:    begin
        st = shift_err;
        r  = shift_err ? '0 : (rv << sh);
      end
      CMD_LSR:    begin
        st = shift_err;
        r  = shift_err ? '0 : (rv >> sh);
      end
      CMD_ASR:    begin
        st = shift_err;
        r  = shift_err ? '0 : data_t'($signed(rv_ext) >>> sh);
      end
      CMD_TRUNC,
      CMD_ZEXT:   r = sa;
      CMD_SEXT:   r = sa_ext;
      CMD_EQ:     r = DATA_W'(sa == sb);
      CMD_NE:     r = DATA_W'(sa != sb);
      CMD_ULT:    r = DATA_W'(sa < sb);
      CMD_SLT:    r = DATA_W'($signed(sa_ext) < $signed(sb_ext));
      CMD_SELECT: r = (item.operand_a != '0) ? item.operand_b : item.operand_c;
      CMD_ADDC:   r = DATA_W'(sum_s < sa);
      CMD_SUBC:   r = DATA_W'(sa >= sb);
      CMD_ADDV:   r = DATA_W'(top_bit(~(sa ^ sb) & (sa ^ sum_s), sw));
      CMD_SUBV:   r = DATA_W'(top_bit((sa ^ sb) & (sa ^ diff_s), sw));
      CMD_COND:   r = DATA_W'(cond_ok);
      default:    r = '0;
    endcase
  end

  assign result.result_value = r & rmask;
  assign result.status       = st;

endmodule

`default_nettype wire
